### hw/rtl/gsp_pkg.sv
package gsp_pkg;

  typedef struct packed {
    logic [7:0] packed_byte;
    logic       start_of_message;
    logic [7:0] message_septets;
  } gsp_in_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       char_valid;
    logic       last_of_message;
  } gsp_out_t;

  // One queue entry holds every septet that a single input byte produced.
  typedef struct packed {
    logic       start;
    logic [7:0] length;
    logic       two;
    logic [6:0] s0;
    logic [6:0] s1;
  } gsp_entry_t;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QptrW      = $clog2(QueueDepth);
  localparam int unsigned QcntW      = $clog2(QueueDepth + 1);

  localparam logic [6:0] EscSeptet = 7'h1B;
  localparam logic [7:0] UnmappedChar = 8'h3F;
  localparam logic [2:0] MaxLeftover = 3'd6;

  localparam logic [7:0] AlphaRom [0:127] = '{
    8'h40, 8'hA3, 8'h24, 8'hA5, 8'hE8, 8'hE9, 8'hF9, 8'hEC,
    8'hF2, 8'hC7, 8'h0A, 8'hD8, 8'hF8, 8'h0D, 8'hC5, 8'hE5,
    8'h3F, 8'h5F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F,
    8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'hC6, 8'hE6, 8'hDF, 8'hC9,
    8'h20, 8'h21, 8'h22, 8'h23, 8'hA4, 8'h25, 8'h26, 8'h27,
    8'h28, 8'h29, 8'h2A, 8'h2B, 8'h2C, 8'h2D, 8'h2E, 8'h2F,
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h3A, 8'h3B, 8'h3C, 8'h3D, 8'h3E, 8'h3F,
    8'hA1, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47,
    8'h48, 8'h49, 8'h4A, 8'h4B, 8'h4C, 8'h4D, 8'h4E, 8'h4F,
    8'h50, 8'h51, 8'h52, 8'h53, 8'h54, 8'h55, 8'h56, 8'h57,
    8'h58, 8'h59, 8'h5A, 8'hC4, 8'hD6, 8'hD1, 8'hDC, 8'hA7,
    8'hBF, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66, 8'h67,
    8'h68, 8'h69, 8'h6A, 8'h6B, 8'h6C, 8'h6D, 8'h6E, 8'h6F,
    8'h70, 8'h71, 8'h72, 8'h73, 8'h74, 8'h75, 8'h76, 8'h77,
    8'h78, 8'h79, 8'h7A, 8'hE4, 8'hF6, 8'hF1, 8'hFC, 8'hE0
  };

  function automatic logic [7:0] ext_map(input logic [6:0] s);
    logic [7:0] code;
    unique case (s)
      7'h0A:   code = 8'h0A;
      7'h14:   code = 8'h5E;
      7'h28:   code = 8'h7B;
      7'h29:   code = 8'h7D;
      7'h2F:   code = 8'h5C;
      7'h3C:   code = 8'h5B;
      7'h3D:   code = 8'h7E;
      7'h3E:   code = 8'h5D;
      7'h40:   code = 8'h7C;
      default: code = UnmappedChar;
    endcase
    return code;
  endfunction

endpackage

### hw/rtl/gsm_septet_unpacker_unit.sv
// Channel  | Signals                                     | Payload
// packed   | packed_valid, packed_ready, packed_item     | one packed byte, start, length
// decoded  | decoded_valid, decoded_ready, decoded_item  | one character, valid, last
//
// A byte is taken on a packed handshake; the front unpacks it into one or two septets
// and queues them in a two-entry queue.
// The back decodes one septet per cycle unless the decoded channel stalls.
// Sustained rate is one byte per cycle for one-septet bytes unless the output stalls.
// Reset clears the bit buffer, escape flag, septet count and queue.
// A stalled decoded channel holds its result and fills the queue, then drops
// packed_ready.
module gsm_septet_unpacker_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              packed_valid,
  output logic              packed_ready,
  input  gsp_pkg::gsp_in_t  packed_item,
  output logic              decoded_valid,
  input  logic              decoded_ready,
  output gsp_pkg::gsp_out_t decoded_item
);
  import gsp_pkg::*;

  logic       push;
  logic       pop;
  logic       queue_full;
  logic       head_valid;
  gsp_entry_t push_entry;
  gsp_entry_t head_entry;

  gsp_front u_front (
    .clk          (clk),
    .rst          (rst),
    .packed_valid (packed_valid),
    .packed_ready (packed_ready),
    .packed_item  (packed_item),
    .push         (push),
    .push_entry   (push_entry),
    .queue_full   (queue_full)
  );

  gsp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_entry (head_entry)
  );

  gsp_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (head_valid),
    .head_entry    (head_entry),
    .pop           (pop),
    .decoded_valid (decoded_valid),
    .decoded_ready (decoded_ready),
    .decoded_item  (decoded_item)
  );

endmodule

### hw/rtl/gsp_front.sv
module gsp_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                packed_valid,
  output logic                packed_ready,
  input  gsp_pkg::gsp_in_t    packed_item,
  output logic                push,
  output gsp_pkg::gsp_entry_t push_entry,
  input  logic                queue_full
);
  import gsp_pkg::*;

  logic [5:0]  leftover_bits;
  logic [2:0]  leftover_count;
  logic [5:0]  leftover_bits_next;
  logic [2:0]  leftover_count_next;
  logic [2:0]  cnt_eff;
  logic [5:0]  bits_eff;
  logic [13:0] buffer;
  logic        two;

  assign packed_ready = !queue_full;
  assign push         = packed_valid && packed_ready;

  always_comb begin
    cnt_eff  = packed_item.start_of_message ? 3'd0 : leftover_count;
    bits_eff = packed_item.start_of_message ? 6'd0 : leftover_bits;
    buffer   = {8'd0, bits_eff} | ({6'd0, packed_item.packed_byte} << cnt_eff);
    // Six buffered bits plus a full byte make exactly two septets.
    two      = (cnt_eff == MaxLeftover);
    if (two) begin
      leftover_bits_next  = 6'd0;
      leftover_count_next = 3'd0;
    end else begin
      leftover_bits_next  = buffer[12:7];
      leftover_count_next = cnt_eff + 3'd1;
    end
    push_entry.start  = packed_item.start_of_message;
    push_entry.length = packed_item.message_septets;
    push_entry.two    = two;
    push_entry.s0     = buffer[6:0];
    push_entry.s1     = buffer[13:7];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      leftover_bits  <= 6'd0;
      leftover_count <= 3'd0;
    end else if (push) begin
      leftover_bits  <= leftover_bits_next;
      leftover_count <= leftover_count_next;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    leftover_count <= MaxLeftover)
    else $error("leftover count out of range");

  a_two_clears: assert property (@(posedge clk) disable iff (rst)
    push && push_entry.two |=> leftover_count == 3'd0)
    else $error("two-septet beat left bits behind");

  a_start_resets: assert property (@(posedge clk) disable iff (rst)
    push && packed_item.start_of_message |=> leftover_count == 3'd1)
    else $error("start beat did not restart bit buffer");

endmodule

### hw/rtl/gsp_queue.sv
module gsp_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  gsp_pkg::gsp_entry_t push_entry,
  output logic                full,
  input  logic                pop,
  output logic                head_valid,
  output gsp_pkg::gsp_entry_t head_entry
);
  import gsp_pkg::*;

  gsp_entry_t       slots [QueueDepth];
  logic [QptrW-1:0] wr_ptr;
  logic [QptrW-1:0] rd_ptr;
  logic [QcntW-1:0] count;

  assign full       = (count == QcntW'(QueueDepth));
  assign head_valid = (count != '0);
  assign head_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QptrW'(QueueDepth - 1)) ? '0 : wr_ptr + QptrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QptrW'(QueueDepth - 1)) ? '0 : rd_ptr + QptrW'(1);
      end
      if (push && !pop) begin
        count <= count + QcntW'(1);
      end else if (pop && !push) begin
        count <= count - QcntW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("pop from empty queue");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QcntW'(QueueDepth))
    else $error("queue count out of range");

endmodule

### hw/rtl/gsp_back.sv
module gsp_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                head_valid,
  input  gsp_pkg::gsp_entry_t head_entry,
  output logic                pop,
  output logic                decoded_valid,
  input  logic                decoded_ready,
  output gsp_pkg::gsp_out_t   decoded_item
);
  import gsp_pkg::*;

  logic [7:0] septets_left;
  logic       escape_pending;
  logic       idx;
  logic [7:0] septets_left_next;
  logic       escape_pending_next;
  logic       step;
  logic       first;
  logic       done_entry;
  logic [6:0] septet;
  logic [7:0] left_eff;
  logic       esc_eff;
  logic       emit;
  gsp_out_t   result;

  assign step       = head_valid && (!decoded_valid || decoded_ready);
  assign first      = !idx;
  assign done_entry = !head_entry.two || idx;
  assign pop        = step && done_entry;

  always_comb begin
    septet    = idx ? head_entry.s1 : head_entry.s0;
    // A start beat loads the length and clears the escape before its first septet.
    left_eff  = (first && head_entry.start) ? head_entry.length : septets_left;
    esc_eff   = (first && head_entry.start) ? 1'b0 : escape_pending;
    emit      = 1'b0;
    result    = '0;
    septets_left_next   = left_eff;
    escape_pending_next = esc_eff;
    if (left_eff != 8'd0) begin
      septets_left_next      = left_eff - 8'd1;
      result.last_of_message = (septets_left_next == 8'd0);
      result.char_valid      = 1'b1;
      if (esc_eff) begin
        escape_pending_next = 1'b0;
        result.char_code    = ext_map(septet);
        emit                = 1'b1;
      end else if (septet == EscSeptet) begin
        if (!result.last_of_message) begin
          escape_pending_next = 1'b1;
        end else begin
          // Escape with nothing after it: flagged as not a character.
          result.char_valid = 1'b0;
          emit              = 1'b1;
        end
      end else begin
        result.char_code = AlphaRom[septet];
        emit             = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      septets_left   <= 8'd0;
      escape_pending <= 1'b0;
      idx            <= 1'b0;
      decoded_valid  <= 1'b0;
    end else begin
      if (step) begin
        septets_left   <= septets_left_next;
        escape_pending <= escape_pending_next;
        idx            <= !done_entry;
      end
      if (step && emit) begin
        decoded_valid <= 1'b1;
      end else if (decoded_ready) begin
        decoded_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      decoded_item <= result;
    end
  end

  a_last_empties: assert property (@(posedge clk) disable iff (rst)
    step && emit && result.last_of_message |=> septets_left == 8'd0)
    else $error("last result left septets pending");

  a_escape_needs_length: assert property (@(posedge clk) disable iff (rst)
    escape_pending |-> septets_left != 8'd0)
    else $error("escape pending with no septets left");

  a_invalid_is_last: assert property (@(posedge clk) disable iff (rst)
    decoded_valid && !decoded_item.char_valid |-> decoded_item.last_of_message)
    else $error("dangling escape result not marked last");

  a_second_half: assert property (@(posedge clk) disable iff (rst)
    idx |-> head_valid && head_entry.two)
    else $error("second septet selected without a two-septet entry");

endmodule
